// ===== hw/rtl/sird_pkg.sv =====
`timescale 1ns / 1ps
// sird_pkg: shared types and constants for the signed integer to radix digits block
// no dependencies; used by the divider, the top level and the checker

package sird_pkg;

    // data path
    localparam int DATA_W       = 32;
    localparam int CHAR_W       = 8;
    localparam int DIGIT_W      = 6;
    localparam int RADIX_W      = 6;
    localparam int MAX_DIGITS   = 32;
    localparam int DIGIT_IDX_W  = $clog2(MAX_DIGITS);
    localparam int COUNT_W      = DIGIT_IDX_W + 1;

    // default upper bound on the radix (2..48)
    localparam int MAX_RADIX_DEFAULT = 32;

    // iterative divider: quotient bits retired per cycle
    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES         = DATA_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_PLUS     = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS    = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE     = 8'h00;
    localparam logic [CHAR_W-1:0] SYM_BELOW_MIN = 8'd32;
    localparam logic [CHAR_W-1:0] SYM_ABOVE_MAX = 8'd127;

    // configuration port
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;
    localparam int NUM_ALPHA_WORDS = 6;
    localparam logic [REG_IDX_W-1:0] REG_RADIX_SIZE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ALPHABET_0 = 3'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SIGN,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT,
        ST_ERROR
    } state_t;

endpackage

// ===== hw/rtl/sird_divider.sv =====
`timescale 1ns / 1ps
// sird_divider: iterative restoring divider, 32-bit dividend by a 6-bit divisor
// depends on sird_pkg; retires DIV_BITS_PER_CYCLE quotient bits per cycle

module sird_divider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [sird_pkg::DATA_W-1:0]      dividend,
    input  logic [sird_pkg::RADIX_W-1:0]     divisor,
    output logic                             done,
    output logic [sird_pkg::DATA_W-1:0]      quotient,
    output logic [sird_pkg::DIGIT_W-1:0]     remainder
);

    logic [sird_pkg::DATA_W-1:0]    work_reg, work_next;
    logic [sird_pkg::DIGIT_W-1:0]   rem_reg, rem_next;
    logic [sird_pkg::RADIX_W-1:0]   div_reg;
    logic [sird_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    // DIV_BITS_PER_CYCLE restoring steps on the narrow remainder
    always_comb begin
        logic [sird_pkg::DIGIT_W:0] shifted;
        work_next = work_reg;
        rem_next  = rem_reg;
        for (int i = 0; i < sird_pkg::DIV_BITS_PER_CYCLE; i++) begin
            shifted   = {rem_next, work_next[sird_pkg::DATA_W-1]};
            work_next = {work_next[sird_pkg::DATA_W-2:0], 1'b0};
            if (shifted >= {1'b0, div_reg}) begin
                rem_next     = sird_pkg::DIGIT_W'(shifted - {1'b0, div_reg});
                work_next[0] = 1'b1;
            end else begin
                rem_next = shifted[sird_pkg::DIGIT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == sird_pkg::DIV_CNT_W'(sird_pkg::DIV_CYCLES - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end else if (busy_reg) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/signed_integer_to_radix_digits.sv =====
`timescale 1ns / 1ps
// signed_integer_to_radix_digits: signed 32-bit number to text in a configured radix
// depends on sird_pkg and sird_divider
//
// usage
//   s_ channel takes one item, a signed 32-bit number in s_tdata
//   m_ channel gives one item per character: m_tdata holds the character,
//   m_tlast marks the last character of a number, m_tuser flags a bad alphabet
//   (then a single item with m_tdata zero and m_tlast high)
//   characters come most significant digit first, led by '-' for negatives
//   the APB port holds the radix (register 0) and six 64-bit alphabet words,
//   eight symbols each, at byte addresses 8*i; write only while idle
// timing
//   s_tready is high only in the idle state; one number is worked at a time
//   alphabet check: one symbol per cycle, done once after any
//   register write and then cached for later numbers
//   digits: each comes from the shared iterative divider, which
//   retires 4 quotient bits per cycle; emission one character per cycle
//   while the m_ side is not stalled
// reset and stall
//   aresetn clears the control and configuration registers, the radix to 0
//   (an invalid alphabet)
//   a stalled m_ side holds the pending character in the output register;
//   the sequencer waits, nothing is dropped

module signed_integer_to_radix_digits #(
    parameter int MAX_RADIX = sird_pkg::MAX_RADIX_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input item channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic signed [sird_pkg::DATA_W-1:0] s_tdata,   // [31:0] value
    // result item channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sird_pkg::CHAR_W-1:0]        m_tdata,   // [7:0] char_out
    output logic                               m_tlast,   // last_char
    output logic                               m_tuser,   // [0] bad_alphabet
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sird_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sird_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sird_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    // only the alphabet words the radix bound can reach feed the lookup
    localparam int NUM_WORDS   = (MAX_RADIX + 7) / 8;
    localparam int ALPHA_BYTES = NUM_WORDS * 8;
    localparam int SYM_IDX_W   = $clog2(ALPHA_BYTES);

    // configuration registers
    logic [sird_pkg::RADIX_W-1:0]    radix_reg;
    logic [sird_pkg::APB_DATA_W-1:0] alpha_reg [sird_pkg::NUM_ALPHA_WORDS];
    logic [sird_pkg::REG_IDX_W-1:0]  cfg_idx;
    logic                            cfg_wr;

    // sequencer and data path
    sird_pkg::state_t                state_reg, state_next;
    logic                            neg_reg, neg_next;
    logic [sird_pkg::DATA_W-1:0]     mag_reg, mag_next;
    logic [sird_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [sird_pkg::RADIX_W-1:0]    idx_reg, idx_next;
    logic [127:0]                    seen_reg, seen_next;
    logic                            known_reg, known_next;
    logic                            ok_reg, ok_next;
    logic [sird_pkg::DIGIT_W-1:0]    stack_mem [sird_pkg::MAX_DIGITS];
    logic                            stack_we;

    // output register
    logic                            out_valid_reg, out_valid_next;
    logic [sird_pkg::CHAR_W-1:0]     out_char_reg, out_char_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_bad_reg, out_bad_next;
    logic                            slot_free;

    // divider
    logic                            div_start;
    logic                            div_done;
    logic [sird_pkg::DATA_W-1:0]     div_quo;
    logic [sird_pkg::DIGIT_W-1:0]    div_rem;

    // symbol lookup, shared by the check and the emission
    logic [sird_pkg::CHAR_W-1:0]     alpha_bytes [ALPHA_BYTES];
    logic [sird_pkg::COUNT_W-1:0]    count_m1;
    logic [sird_pkg::RADIX_W-1:0]    sym_sel;
    logic [sird_pkg::CHAR_W-1:0]     sym;
    logic                            sym_bad;
    logic                            radix_ok;
    logic [sird_pkg::DATA_W-1:0]     in_value;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[sird_pkg::APB_ADDR_W-1:sird_pkg::APB_ADDR_W-sird_pkg::REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= '0;
            for (int w = 0; w < sird_pkg::NUM_ALPHA_WORDS; w++) begin
                alpha_reg[w] <= '0;
            end
        end else if (cfg_wr) begin
            if (cfg_idx == sird_pkg::REG_RADIX_SIZE) begin
                radix_reg <= pwdata[sird_pkg::RADIX_W-1:0];
            end
            for (int w = 0; w < sird_pkg::NUM_ALPHA_WORDS; w++) begin
                if (cfg_idx == sird_pkg::REG_IDX_W'(int'(sird_pkg::REG_ALPHABET_0) + w)) begin
                    alpha_reg[w] <= pwdata;
                end
            end
        end
    end

    // index past the register list reads as zero
    always_comb begin
        prdata = '0;
        if (cfg_idx == sird_pkg::REG_RADIX_SIZE) begin
            prdata = sird_pkg::APB_DATA_W'(radix_reg);
        end
        for (int w = 0; w < sird_pkg::NUM_ALPHA_WORDS; w++) begin
            if (cfg_idx == sird_pkg::REG_IDX_W'(int'(sird_pkg::REG_ALPHABET_0) + w)) begin
                prdata = alpha_reg[w];
            end
        end
    end

    // ---------------- symbol lookup ----------------
    always_comb begin
        for (int w = 0; w < NUM_WORDS; w++) begin
            for (int b = 0; b < 8; b++) begin
                alpha_bytes[w*8 + b] = alpha_reg[w][8*b +: 8];
            end
        end
    end

    assign count_m1 = count_reg - 1'b1;
    // check walks the alphabet, emission pops the digit stack
    assign sym_sel  = (state_reg == sird_pkg::ST_CHECK) ? idx_reg
                                                        : stack_mem[count_m1[sird_pkg::DIGIT_IDX_W-1:0]];
    assign sym      = alpha_bytes[sym_sel[SYM_IDX_W-1:0]];

    // out of range, a sign, or already seen earlier in the alphabet
    assign sym_bad  = (sym == sird_pkg::CHAR_PLUS) || (sym == sird_pkg::CHAR_MINUS) ||
                      (sym <= sird_pkg::SYM_BELOW_MIN) || (sym >= sird_pkg::SYM_ABOVE_MAX) ||
                      seen_reg[sym[6:0]];

    assign radix_ok = (radix_reg >= sird_pkg::RADIX_W'(2)) &&
                      (radix_reg <= sird_pkg::RADIX_W'(MAX_RADIX));

    assign in_value = s_tdata;
    assign slot_free = !out_valid_reg || m_tready;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        seen_next      = seen_reg;
        known_next     = known_reg;
        ok_next        = ok_reg;
        stack_we       = 1'b0;
        div_start      = 1'b0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;

        case (state_reg)
            sird_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    neg_next   = in_value[sird_pkg::DATA_W-1];
                    // two's complement magnitude, the most negative value stays 2^31
                    mag_next   = in_value[sird_pkg::DATA_W-1] ? (~in_value + 1'b1) : in_value;
                    count_next = '0;
                    if (known_reg) begin
                        if (!ok_reg) begin
                            state_next = sird_pkg::ST_ERROR;
                        end else if (in_value[sird_pkg::DATA_W-1]) begin
                            state_next = sird_pkg::ST_SIGN;
                        end else begin
                            state_next = sird_pkg::ST_DIV_START;
                        end
                    end else if (!radix_ok) begin
                        known_next = 1'b1;
                        ok_next    = 1'b0;
                        state_next = sird_pkg::ST_ERROR;
                    end else begin
                        idx_next   = '0;
                        seen_next  = '0;
                        state_next = sird_pkg::ST_CHECK;
                    end
                end
            end

            sird_pkg::ST_CHECK: begin
                if (sym_bad) begin
                    known_next = 1'b1;
                    ok_next    = 1'b0;
                    state_next = sird_pkg::ST_ERROR;
                end else begin
                    seen_next[sym[6:0]] = 1'b1;
                    idx_next            = idx_reg + 1'b1;
                    if (idx_reg == radix_reg - 1'b1) begin
                        known_next = 1'b1;
                        ok_next    = 1'b1;
                        state_next = neg_reg ? sird_pkg::ST_SIGN : sird_pkg::ST_DIV_START;
                    end
                end
            end

            sird_pkg::ST_SIGN: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = sird_pkg::CHAR_MINUS;
                    out_last_next  = 1'b0;
                    out_bad_next   = 1'b0;
                    state_next     = sird_pkg::ST_DIV_START;
                end
            end

            sird_pkg::ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = sird_pkg::ST_DIV_WAIT;
            end

            sird_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    stack_we   = 1'b1;
                    mag_next   = div_quo;
                    count_next = count_reg + 1'b1;
                    if ((div_quo != '0) &&
                        (count_reg != sird_pkg::COUNT_W'(sird_pkg::MAX_DIGITS - 1))) begin
                        state_next = sird_pkg::ST_DIV_START;
                    end else begin
                        state_next = sird_pkg::ST_EMIT;
                    end
                end
            end

            sird_pkg::ST_EMIT: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = sym;
                    out_last_next  = (count_m1 == '0);
                    out_bad_next   = 1'b0;
                    count_next     = count_m1;
                    if (count_m1 == '0) begin
                        state_next = sird_pkg::ST_IDLE;
                    end
                end
            end

            sird_pkg::ST_ERROR: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = sird_pkg::CHAR_NONE;
                    out_last_next  = 1'b1;
                    out_bad_next   = 1'b1;
                    state_next     = sird_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = sird_pkg::ST_IDLE;
            end
        endcase

        // any register write invalidates the cached alphabet verdict
        if (cfg_wr) begin
            known_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sird_pkg::ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            known_reg     <= 1'b0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            known_reg     <= known_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        seen_reg     <= seen_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
        if (stack_we) begin
            stack_mem[count_reg[sird_pkg::DIGIT_IDX_W-1:0]] <= div_rem;
        end
    end

    // ---------------- shared divider ----------------
    sird_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (radix_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_bad_reg;

endmodule

// ===== hw/rtl/sird_checker.sv =====
`timescale 1ns / 1ps
// sird_checker: port-level assertions for signed_integer_to_radix_digits
// depends on sird_pkg; attached to the top level by the bind below

module sird_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [sird_pkg::CHAR_W-1:0] m_tdata,
    input logic                        m_tlast,
    input logic                        m_tuser
);

    // a stalled item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
                                  $stable(m_tuser))
        else $error("stalled result item changed");

    // one number at a time: busy right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a number is in work");

    // a bad alphabet item is a lone empty final item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == sird_pkg::CHAR_NONE))
        else $error("bad alphabet item not final or not empty");

    // characters before the last never carry the error flag and are never zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !m_tuser && (m_tdata != sird_pkg::CHAR_NONE))
        else $error("error flag on a non-final character");

endmodule

bind signed_integer_to_radix_digits sird_checker u_sird_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
